>>> sv/spor_pkg.sv
`timescale 1ns / 1ps

package spor_pkg;

  localparam int unsigned COORD_WIDTH  = 32;
  localparam int unsigned RADIUS_WIDTH = COORD_WIDTH - 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic        [RADIUS_WIDTH-1:0] first_radius;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic        [RADIUS_WIDTH-1:0] second_radius;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] new_first_x;
    logic signed [COORD_WIDTH-1:0] new_first_y;
    logic signed [COORD_WIDTH-1:0] new_first_z;
    logic signed [COORD_WIDTH-1:0] new_second_x;
    logic signed [COORD_WIDTH-1:0] new_second_y;
    logic signed [COORD_WIDTH-1:0] new_second_z;
    logic                          hit;
  } out_item_t;

endpackage

>>> sv/sphere_pair_overlap_resolve.sv
`timescale 1ns / 1ps

// sphere pair overlap resolver: takes one pair of spheres (centres and radii in
// fixed point) per cycle and returns both centres pushed apart along the line
// between them by the overlap depth, with hit set, or unchanged with hit clear
// when they do not overlap or their centres coincide. results saturate to the
// coordinate range. the block is fully pipelined: one item per cycle in and
// out while the output is not stalled. the pipe holds the digit-by-digit
// square root (one result bit per stage) and the restoring divider for the
// unit normal (one quotient bit per stage, three lanes side by side). a stall
// on the result side freezes the whole pipe, so in_stall follows out_stall
// while a result is waiting.
module sphere_pair_overlap_resolve (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spor_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spor_pkg::out_item_t  out_data
);

  localparam int W   = spor_pkg::COORD_WIDTH;
  localparam int DW  = W + 1;          // centre difference and its magnitude
  localparam int SW  = 2 * W + 2;      // sum of squares
  localparam int RT  = W + 1;          // square root bits
  localparam int NW  = 2 * W + 1;      // magnitude times depth
  // stage map
  localparam int SQ0 = 3;              // first square root step
  localparam int DEP = SQ0 + RT;       // depth
  localparam int MUL = DEP + 1;        // magnitude times depth
  localparam int DV0 = MUL + 1;        // first divider step
  localparam int RND = DV0 + W;        // rounding and sign
  localparam int NS  = RND + 1;

  typedef struct packed {
    logic [2:0][W-1:0]    a;           // first centre
    logic [2:0][W-1:0]    b;           // second centre
    logic [2:0]           neg;         // difference sign per axis
    logic [2:0][DW-1:0]   mag;         // difference magnitude per axis
    logic [W-1:0]         rsum;        // radius sum
    logic [2:0][SW-1:0]   sq;          // squared magnitudes
    logic [2*W-1:0]       rr;          // radius sum squared
    logic [SW-1:0]        s;           // squared distance
    logic                 hit;
    logic [W:0]           root;        // square root, partial then final
    logic [W+3:0]         srem;        // square root remainder
    logic [W-1:0]         depth;
    logic [2:0][NW-1:0]   num;         // divider numerators
    logic [2:0][W:0]      drem;        // divider remainders
    logic [2:0][W-1:0]    quo;         // quotients
    logic [2:0][W+1:0]    push;        // signed push per axis
  } pipe_t;

  pipe_t           st_r   [NS];
  pipe_t           st_nxt [NS];
  logic [NS-1:0]   v_r;
  logic            adv;
  logic            out_valid_r;
  spor_pkg::out_item_t out_data_r;
  spor_pkg::out_item_t out_nxt;

  // whole pipe moves unless a finished item is held at the output
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stage 0: unpack, differences, magnitudes, radius sum
  always_comb begin
    logic signed [DW-1:0] d;
    st_nxt[0] = '0;
    st_nxt[0].a[0] = in_data.first_x;
    st_nxt[0].a[1] = in_data.first_y;
    st_nxt[0].a[2] = in_data.first_z;
    st_nxt[0].b[0] = in_data.second_x;
    st_nxt[0].b[1] = in_data.second_y;
    st_nxt[0].b[2] = in_data.second_z;
    for (int k = 0; k < 3; k++) begin
      d = DW'($signed(st_nxt[0].a[k])) - DW'($signed(st_nxt[0].b[k]));
      st_nxt[0].neg[k] = d[DW-1];
      st_nxt[0].mag[k] = d[DW-1] ? DW'(-d) : DW'(d);
    end
    st_nxt[0].rsum = W'({1'b0, in_data.first_radius}) + W'({1'b0, in_data.second_radius});
  end

  // stage 1: squares
  always_comb begin
    st_nxt[1] = st_r[0];
    for (int k = 0; k < 3; k++) begin
      st_nxt[1].sq[k] = SW'(st_r[0].mag[k] * st_r[0].mag[k]);
    end
    st_nxt[1].rr = st_r[0].rsum * st_r[0].rsum;
  end

  // stage 2: squared distance, overlap test, square root start
  always_comb begin
    logic [SW-1:0] s;
    s = st_r[1].sq[0] + st_r[1].sq[1] + st_r[1].sq[2];
    st_nxt[2]      = st_r[1];
    st_nxt[2].s    = s;
    st_nxt[2].hit  = (s != '0) && ({2'b00, st_r[1].rr} > s);
    st_nxt[2].root = '0;
    st_nxt[2].srem = '0;
  end

  // square root, two radicand bits per stage
  for (genvar k = 0; k < RT; k++) begin : g_sqrt
    pipe_t nxt;
    always_comb begin
      logic [W+3:0] tr;
      logic [W+3:0] trial;
      nxt   = st_r[SQ0+k-1];
      tr    = {st_r[SQ0+k-1].srem[W+1:0], st_r[SQ0+k-1].s[SW-1-2*k -: 2]};
      trial = {1'b0, st_r[SQ0+k-1].root, 2'b01};
      if (tr >= trial) begin
        nxt.srem = tr - trial;
        nxt.root = {st_r[SQ0+k-1].root[W-1:0], 1'b1};
      end else begin
        nxt.srem = tr;
        nxt.root = {st_r[SQ0+k-1].root[W-1:0], 1'b0};
      end
    end
    assign st_nxt[SQ0+k] = nxt;
  end

  // depth; on a hit the root is below the radius sum
  always_comb begin
    st_nxt[DEP]       = st_r[DEP-1];
    st_nxt[DEP].depth = st_r[DEP-1].rsum - st_r[DEP-1].root[W-1:0];
  end

  // numerators, divider start
  always_comb begin
    st_nxt[MUL] = st_r[MUL-1];
    for (int k = 0; k < 3; k++) begin
      st_nxt[MUL].num[k]  = st_r[MUL-1].mag[k] * st_r[MUL-1].depth;
      st_nxt[MUL].drem[k] = st_nxt[MUL].num[k][NW-1:W];
      st_nxt[MUL].quo[k]  = '0;
    end
  end

  // restoring divider by the length, one quotient bit per stage
  for (genvar j = 0; j < W; j++) begin : g_div
    pipe_t nxt;
    always_comb begin
      logic [W:0] t;
      logic [W:0] den;
      nxt = st_r[DV0+j-1];
      den = {1'b0, st_r[DV0+j-1].root[W-1:0]};
      for (int k = 0; k < 3; k++) begin
        t = {st_r[DV0+j-1].drem[k][W-1:0], st_r[DV0+j-1].num[k][W-1-j]};
        if (t >= den) begin
          nxt.drem[k] = t - den;
          nxt.quo[k]  = {st_r[DV0+j-1].quo[k][W-2:0], 1'b1};
        end else begin
          nxt.drem[k] = t;
          nxt.quo[k]  = {st_r[DV0+j-1].quo[k][W-2:0], 1'b0};
        end
      end
    end
    assign st_nxt[DV0+j] = nxt;
  end

  // round half up on magnitude, then apply the axis sign
  always_comb begin
    logic [W:0] den;
    logic [W:0] p;
    st_nxt[RND] = st_r[RND-1];
    den = {1'b0, st_r[RND-1].root[W-1:0]};
    for (int k = 0; k < 3; k++) begin
      p = {1'b0, st_r[RND-1].quo[k]} +
          (W+1)'({st_r[RND-1].drem[k][W-1:0], 1'b0} >= den);
      st_nxt[RND].push[k] = st_r[RND-1].neg[k] ? (W+2)'(-$signed({1'b0, p}))
                                               : {1'b0, p};
    end
  end

  // output stage: apply push and saturate
  always_comb begin
    logic signed [W+2:0] na [3];
    logic signed [W+2:0] nb [3];
    logic [W-1:0]        ra [3];
    logic [W-1:0]        rb [3];
    logic signed [W+2:0] smax;
    logic signed [W+2:0] smin;
    smax = (W+3)'({1'b0, {(W-1){1'b1}}});
    smin = -smax - 1;
    for (int k = 0; k < 3; k++) begin
      na[k] = (W+3)'($signed(st_r[RND].a[k])) + (W+3)'($signed(st_r[RND].push[k]));
      nb[k] = (W+3)'($signed(st_r[RND].b[k])) - (W+3)'($signed(st_r[RND].push[k]));
      if (!st_r[RND].hit) begin
        ra[k] = st_r[RND].a[k];
        rb[k] = st_r[RND].b[k];
      end else begin
        ra[k] = (na[k] > smax) ? smax[W-1:0] : (na[k] < smin) ? smin[W-1:0] : na[k][W-1:0];
        rb[k] = (nb[k] > smax) ? smax[W-1:0] : (nb[k] < smin) ? smin[W-1:0] : nb[k][W-1:0];
      end
    end
    out_nxt.new_first_x  = ra[0];
    out_nxt.new_first_y  = ra[1];
    out_nxt.new_first_z  = ra[2];
    out_nxt.new_second_x = rb[0];
    out_nxt.new_second_y = rb[1];
    out_nxt.new_second_z = rb[2];
    out_nxt.hit          = st_r[RND].hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[NS-2:0], in_valid};
      out_valid_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) begin
        st_r[i] <= st_nxt[i];
      end
      out_data_r <= out_nxt;
    end
  end

`ifndef SYNTH
  // a held result freezes every stage
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(v_r))
    else $error("pipe moved while output stalled");

  // an overlap always has a nonzero length below the radius sum
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[DEP-1] && st_r[DEP-1].hit) |->
      (st_r[DEP-1].root != '0) && (st_r[DEP-1].root < {1'b0, st_r[DEP-1].rsum}))
    else $error("bad length on overlap");

  // divider remainder stays below the length
  a_drem: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[RND-1] && st_r[RND-1].hit) |->
      (st_r[RND-1].drem[0] < {1'b0, st_r[RND-1].root[W-1:0]}) &&
      (st_r[RND-1].drem[1] < {1'b0, st_r[RND-1].root[W-1:0]}) &&
      (st_r[RND-1].drem[2] < {1'b0, st_r[RND-1].root[W-1:0]}))
    else $error("divider remainder out of range");
`endif

endmodule

>>> sim/tb_sphere_pair_overlap_resolve.sv
`timescale 1ns / 1ps

// scoreboard: predicts the resolved centres for every accepted pair and
// checks results in order
class overlap_scoreboard;
  spor_pkg::out_item_t pending_q[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned hits;

  function new();
    errors = 0;
    checked = 0;
    hits = 0;
  endfunction

  // integer square root, floor
  static function logic [63:0] isqrt(logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  static function logic signed [31:0] clamp(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function spor_pkg::out_item_t resolve(spor_pkg::in_item_t it);
    spor_pkg::out_item_t res;
    logic signed [33:0] a [3];
    logic signed [33:0] b [3];
    logic signed [33:0] d [3];
    logic [33:0] mag [3];
    logic [127:0] sq;
    logic [127:0] rsq;
    logic [63:0] rsum;
    logic [63:0] len;
    logic [63:0] depth;
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] rem;
    logic signed [65:0] p;
    logic signed [31:0] na [3];
    logic signed [31:0] nb [3];
    a[0] = it.first_x; a[1] = it.first_y; a[2] = it.first_z;
    b[0] = it.second_x; b[1] = it.second_y; b[2] = it.second_z;
    sq = '0;
    for (int k = 0; k < 3; k++) begin
      d[k] = a[k] - b[k];
      mag[k] = d[k] < 0 ? -d[k] : d[k];
      sq += {94'd0, mag[k]} * {94'd0, mag[k]};
      na[k] = a[k][31:0];
      nb[k] = b[k][31:0];
    end
    rsum = {33'd0, it.first_radius} + {33'd0, it.second_radius};
    rsq = {64'd0, rsum} * {64'd0, rsum};
    res.hit = 1'b0;
    // coincident centres give no direction, so no push
    if (sq != 0 && rsq > sq) begin
      res.hit = 1'b1;
      len = isqrt(sq);
      depth = rsum - len;
      for (int k = 0; k < 3; k++) begin
        num = {94'd0, mag[k]} * {64'd0, depth};
        q = num / len;
        rem = num % len;
        // round half away from zero
        if (rem >= len - rem) q++;
        p = $signed({1'b0, q[64:0]});
        if (d[k] < 0) p = -p;
        na[k] = clamp(66'(a[k]) + p);
        nb[k] = clamp(66'(b[k]) - p);
      end
    end
    res.new_first_x = na[0]; res.new_first_y = na[1]; res.new_first_z = na[2];
    res.new_second_x = nb[0]; res.new_second_y = nb[1]; res.new_second_z = nb[2];
    return res;
  endfunction

  function void note_pair(spor_pkg::in_item_t it);
    pending_q = {pending_q, resolve(it)};
  endfunction

  function void check_result(spor_pkg::out_item_t got);
    spor_pkg::out_item_t exp_r;
    if (pending_q.size() == 0) begin
      $error("result with no pair pending: %p", got);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    checked++;
    if (exp_r.hit) hits++;
    if (got.new_first_x !== exp_r.new_first_x) begin
      $error("new_first_x exp %0d got %0d", exp_r.new_first_x, got.new_first_x); errors++;
    end
    if (got.new_first_y !== exp_r.new_first_y) begin
      $error("new_first_y exp %0d got %0d", exp_r.new_first_y, got.new_first_y); errors++;
    end
    if (got.new_first_z !== exp_r.new_first_z) begin
      $error("new_first_z exp %0d got %0d", exp_r.new_first_z, got.new_first_z); errors++;
    end
    if (got.new_second_x !== exp_r.new_second_x) begin
      $error("new_second_x exp %0d got %0d", exp_r.new_second_x, got.new_second_x);
      errors++;
    end
    if (got.new_second_y !== exp_r.new_second_y) begin
      $error("new_second_y exp %0d got %0d", exp_r.new_second_y, got.new_second_y);
      errors++;
    end
    if (got.new_second_z !== exp_r.new_second_z) begin
      $error("new_second_z exp %0d got %0d", exp_r.new_second_z, got.new_second_z);
      errors++;
    end
    if (got.hit !== exp_r.hit) begin
      $error("hit exp %0d got %0d", exp_r.hit, got.hit); errors++;
    end
  endfunction
endclass

module tb_sphere_pair_overlap_resolve;

  localparam int LATENCY = 2 * spor_pkg::COORD_WIDTH + 8;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 200;
  localparam int RANDOM_PAIRS = 800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  spor_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  spor_pkg::out_item_t out_data;

  overlap_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  int unsigned out_wait = 0;

  sphere_pair_overlap_resolve u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // present one pair after a random gap and hold it until accepted
  task automatic send_pair(spor_pkg::in_item_t it);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 9) < 3) gap = 0; // runs without gaps
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_pair(it);
    sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 1 << 20) - (1 << 19);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 31'h7fff_ffff - 31'($urandom_range(0, 3));
      1: return 31'($urandom_range(0, 1 << 20));
      default: return 31'($urandom());
    endcase
  endfunction

  // mostly nearby pairs so that overlaps are common
  function automatic spor_pkg::in_item_t rand_pair();
    spor_pkg::in_item_t it;
    logic [31:0] spread;
    it.first_x = rand_coord();
    it.first_y = rand_coord();
    it.first_z = rand_coord();
    it.first_radius = rand_radius();
    it.second_radius = rand_radius();
    if ($urandom_range(0, 3) == 0) begin
      it.second_x = rand_coord();
      it.second_y = rand_coord();
      it.second_z = rand_coord();
    end else begin
      spread = 32'd1 << $urandom_range(0, 30);
      it.second_x = it.first_x + ($urandom() % spread) - spread / 2;
      it.second_y = it.first_y + ($urandom() % spread) - spread / 2;
      it.second_z = it.first_z + ($urandom() % spread) - spread / 2;
    end
    return it;
  endfunction

  function automatic spor_pkg::in_item_t make_pair(logic [31:0] ax, ay, az, logic [30:0] ar,
                                                   logic [31:0] bx, by, bz, logic [30:0] br);
    spor_pkg::in_item_t it;
    it.first_x = ax; it.first_y = ay; it.first_z = az; it.first_radius = ar;
    it.second_x = bx; it.second_y = by; it.second_z = bz; it.second_radius = br;
    return it;
  endfunction

  // result side: after each result, draw a random wait and stall until it runs out
  always @(posedge clk) begin : out_side
    int unsigned w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait  <= 0;
    end else if (out_valid && !out_stall) begin
      sb.check_result(out_data);
      w = $urandom_range(0, 3);
      out_wait  <= w;
      out_stall <= (w != 0);
    end else if (out_stall) begin
      out_wait  <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("FAIL sphere_pair_overlap_resolve");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: touching, overlap, coincident, extremes, saturation
    send_pair(make_pair(0, 0, 0, 31'h10000, 32'h20000, 0, 0, 31'h10000));
    send_pair(make_pair(0, 0, 0, 31'h10000, 32'h10000, 0, 0, 31'h10000));
    send_pair(make_pair(0, 0, 0, 31'h10000, 0, 32'hffff0000, 0, 31'h10000));
    send_pair(make_pair(5, 6, 7, 31'h7fffffff, 5, 6, 7, 31'h7fffffff));
    send_pair(make_pair(0, 0, 0, 31'd0, 0, 0, 0, 31'd0));
    send_pair(make_pair(0, 0, 0, 31'd0, 1, 0, 0, 31'd0));
    send_pair(make_pair(0, 0, 0, 31'd1, 0, 0, 1, 31'd1));
    send_pair(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                        32'h7ffffff0, 32'h7ffffff0, 32'h7ffffff0, 31'h7fffffff));
    send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff,
                        32'h80000010, 32'h80000010, 32'h80000010, 31'h7fffffff));
    send_pair(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                        32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff));
    send_pair(make_pair(32'h80000000, 0, 32'h7fffffff, 31'h7fffffff,
                        32'h7fffffff, 32'hffffffff, 32'h80000000, 31'h7fffffff));
    send_pair(make_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff,
                        32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h0));
    send_pair(make_pair(3, 0, 0, 31'd2, 0, 0, 0, 31'd2));
    send_pair(make_pair(0, 3, 4, 31'h55555555, 0, 0, 0, 31'h2aaaaaaa));
    send_pair(make_pair(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 31'h2aaaaaaa,
                        32'h55555555, 32'haaaaaaaa, 32'h55555555, 31'h55555555));

    for (int i = 0; i < RANDOM_PAIRS; i++) send_pair(rand_pair());
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("covered %0d pairs, %0d results checked, %0d with overlap push",
             sent, sb.checked, sb.hits);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS sphere_pair_overlap_resolve");
    end else begin
      $display("FAIL sphere_pair_overlap_resolve");
    end
    $finish;
  end

endmodule
